// File: rtl/mixed_radix_index_convert_assert.svh
// Assertion macros for mixed_radix_index_convert
`ifndef MIXED_RADIX_INDEX_CONVERT_ASSERT_SVH
`define MIXED_RADIX_INDEX_CONVERT_ASSERT_SVH

`define MRIC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define MRIC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/mric_pkg.sv
package mric_pkg;
    localparam int NUM_AXES_DEF   = 6;
    localparam int INDEX_BITS_DEF = 32;
    localparam int AXIS_FIELDS    = 6;
    localparam int SIZE_W         = 16;
    localparam int FLAT_W         = 32;
    localparam int CFG_IDX_W      = 3;
    localparam logic MODE_COMPOSE   = 1'b0;
    localparam logic MODE_DECOMPOSE = 1'b1;

    typedef logic [SIZE_W-1:0] size_t;
endpackage

// File: rtl/mric_div_step.sv
// One restoring-division step; a divide by a 16-bit size takes a chain of these.
module mric_div_step #(
    parameter int W = 32
) (
    input  logic              clk,
    input  logic [W-1:0]      quo_i,
    input  logic [W-1:0]      rem_i,
    input  mric_pkg::size_t   div_i,
    output logic [W-1:0]      quo_o,
    output logic [W-1:0]      rem_o
);
    import mric_pkg::*;
    logic [W:0]   trial;
    logic [W-1:0] quo_next;
    logic [W-1:0] rem_next;

    always_comb
    begin
        trial = {rem_i, quo_i[W-1]} - {{(W-SIZE_W+1){1'b0}}, div_i};
        if (trial[W])
        begin
            rem_next = {rem_i[W-2:0], quo_i[W-1]};
            quo_next = {quo_i[W-2:0], 1'b0};
        end
        else
        begin
            rem_next = trial[W-1:0];
            quo_next = {quo_i[W-2:0], 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        quo_o <= quo_next;
        rem_o <= rem_next;
    end
endmodule

// File: rtl/mric_cell.sv
// One axis cell: a W-stage divider pipeline for decompose and a
// multiply-add for compose, whose result runs through a delay chain of equal depth.
module mric_cell #(
    parameter int W = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            vld_i,
    input  logic            mode_i,
    input  logic [W-1:0]    acc_i,
    input  logic [W-1:0]    pitch_i,
    input  mric_pkg::size_t size_i,
    input  mric_pkg::size_t idx_i,
    output logic            vld_o,
    output logic            mode_o,
    output logic [W-1:0]    acc_o,
    output logic [W-1:0]    pitch_o,
    output mric_pkg::size_t idx_o
);
    import mric_pkg::*;
    logic [W-1:0] quo [0:W];
    logic [W-1:0] rem [0:W];
    logic [W-1:0] sum_reg;
    logic [W-1:0] sum_next;
    logic [W-1:0] pd_reg [1:W];
    logic [W-1:0] pt_reg [1:W];
    logic         md_reg [1:W];
    logic [W-1:0] vld_reg;
    size_t        sz_eff;

    assign sz_eff = (size_i == '0) ? size_t'(1) : size_i;
    assign quo[0] = acc_i;
    assign rem[0] = '0;

    genvar g;
    generate
        for (g = 0; g < W; g++)
        begin : g_div
            mric_div_step #(.W(W)) u_step (
                .clk(clk), .quo_i(quo[g]), .rem_i(rem[g]), .div_i(sz_eff),
                .quo_o(quo[g+1]), .rem_o(rem[g+1])
            );
        end
    endgenerate

    assign sum_next = acc_i + W'(pitch_i * {{(W-SIZE_W){1'b0}}, idx_i});

    always_ff @(posedge clk)
    begin
        pd_reg[1] <= sum_next;
        pt_reg[1] <= W'(pitch_i * {{(W-SIZE_W){1'b0}}, sz_eff});
        md_reg[1] <= mode_i;
        for (int i = 2; i <= W; i++)
        begin
            pd_reg[i] <= pd_reg[i-1];
            pt_reg[i] <= pt_reg[i-1];
            md_reg[i] <= md_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[W-2:0], vld_i};
    end

    assign sum_reg = pd_reg[W];
    assign vld_o   = vld_reg[W-1];
    assign mode_o  = md_reg[W];
    assign acc_o   = (md_reg[W] == MODE_DECOMPOSE) ? quo[W] : sum_reg;
    assign pitch_o = pt_reg[W];
    assign idx_o   = (md_reg[W] == MODE_DECOMPOSE) ? rem[W][SIZE_W-1:0] : '0;
endmodule

// File: rtl/mixed_radix_index_convert.sv
// Datapath: one INDEX_BITS-stage cell per axis (at most six) plus the output register.
// Throughput: one request per cycle; busy is always low.
// Reset: asynchronous, active low; clears all axis sizes to 1 and the pipeline valids.
// The receiver cannot stall: done pulses one cycle with the result.
module mixed_radix_index_convert #(
    parameter int NUM_AXES   = mric_pkg::NUM_AXES_DEF,
    parameter int INDEX_BITS = mric_pkg::INDEX_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         mode,
    input  logic [mric_pkg::FLAT_W-1:0]  flat_in,
    input  mric_pkg::size_t              index_in_0,
    input  mric_pkg::size_t              index_in_1,
    input  mric_pkg::size_t              index_in_2,
    input  mric_pkg::size_t              index_in_3,
    input  mric_pkg::size_t              index_in_4,
    input  mric_pkg::size_t              index_in_5,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mric_pkg::CFG_IDX_W-1:0] cfg_index,
    input  mric_pkg::size_t              cfg_data,
    output logic                         done,
    output logic [mric_pkg::FLAT_W-1:0]  flat_out,
    output mric_pkg::size_t              index_out_0,
    output mric_pkg::size_t              index_out_1,
    output mric_pkg::size_t              index_out_2,
    output mric_pkg::size_t              index_out_3,
    output mric_pkg::size_t              index_out_4,
    output mric_pkg::size_t              index_out_5
);
    import mric_pkg::*;
    localparam int NA = (NUM_AXES < AXIS_FIELDS) ? NUM_AXES : AXIS_FIELDS;
    localparam int W  = INDEX_BITS;
    localparam int LAT = W * NA;

    size_t   size_reg [0:AXIS_FIELDS-1];
    size_t   in_idx   [0:AXIS_FIELDS-1];
    logic          c_vld   [0:NA];
    logic          c_mode  [0:NA];
    logic [W-1:0]  c_acc   [0:NA];
    logic [W-1:0]  c_pitch [0:NA];
    size_t   c_idx [0:NA-1];
    // per-axis index delay so each cell sees its own input when the item arrives
    size_t   idx_dly [0:NA-1][0:LAT];
    size_t   out_dly [0:NA-1][0:LAT];
    logic          done_reg;
    logic [FLAT_W-1:0] flat_reg;
    size_t   idx_out_reg [0:AXIS_FIELDS-1];
    logic [W-1:0] flat_ext;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_idx[0] = index_in_0;
    assign in_idx[1] = index_in_1;
    assign in_idx[2] = index_in_2;
    assign in_idx[3] = index_in_3;
    assign in_idx[4] = index_in_4;
    assign in_idx[5] = index_in_5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i < AXIS_FIELDS; i++)
                size_reg[i] <= size_t'(1);
        else if (cfg_valid && cfg_ready && (int'(cfg_index) < AXIS_FIELDS))
            size_reg[cfg_index] <= cfg_data;
    end

    generate
        if (W >= FLAT_W)
        begin : g_wide
            assign flat_ext = {{(W-FLAT_W){1'b0}}, flat_in};
        end
        else
        begin : g_narrow
            assign flat_ext = flat_in[W-1:0];
        end
    endgenerate

    assign c_vld[0]   = start && !busy;
    assign c_mode[0]  = mode;
    assign c_acc[0]   = (mode == MODE_DECOMPOSE) ? flat_ext : '0;
    assign c_pitch[0] = W'(1);

    genvar k, d;
    generate
        for (k = 0; k < NA; k++)
        begin : g_axis
            localparam int AX  = NA - 1 - k;
            localparam int PRE = W * k;
            localparam int POST = LAT - W * (k + 1);
            assign idx_dly[k][0] = in_idx[AX];
            for (d = 0; d < LAT; d++)
            begin : g_d
                always_ff @(posedge clk)
                begin
                    idx_dly[k][d+1] <= idx_dly[k][d];
                    out_dly[k][d+1] <= out_dly[k][d];
                end
            end
            mric_cell #(.W(W)) u_cell (
                .clk(clk), .rst_n(rst_n),
                .vld_i(c_vld[k]), .mode_i(c_mode[k]), .acc_i(c_acc[k]),
                .pitch_i(c_pitch[k]), .size_i(size_reg[AX]),
                .idx_i(idx_dly[k][PRE]),
                .vld_o(c_vld[k+1]), .mode_o(c_mode[k+1]), .acc_o(c_acc[k+1]),
                .pitch_o(c_pitch[k+1]), .idx_o(c_idx[k])
            );
            assign out_dly[k][0] = c_idx[k];
            always_ff @(posedge clk)
                idx_out_reg[AX] <= (AX == 0) ? out_dly[k][POST] : out_dly[k][POST];
        end
        for (k = NA; k < AXIS_FIELDS; k++)
        begin : g_unused
            always_ff @(posedge clk)
                idx_out_reg[k] <= '0;
        end
    endgenerate

    // axis 0 wraps: its quotient is dropped, remainder kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= c_vld[NA];
    end

    always_ff @(posedge clk)
        flat_reg <= (c_mode[NA] == MODE_DECOMPOSE) ? '0 : FLAT_W'(c_acc[NA]);

    assign done        = done_reg;
    assign flat_out    = flat_reg;
    assign index_out_0 = idx_out_reg[0];
    assign index_out_1 = idx_out_reg[1];
    assign index_out_2 = idx_out_reg[2];
    assign index_out_3 = idx_out_reg[3];
    assign index_out_4 = idx_out_reg[4];
    assign index_out_5 = idx_out_reg[5];
endmodule

// File: rtl/mric_checker.sv
module mric_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic cfg_valid,
    input logic cfg_ready,
    input logic done,
    input logic [mric_pkg::FLAT_W-1:0] flat_out
);
    import mric_pkg::*;
    `include "mixed_radix_index_convert_assert.svh"

    `MRIC_ASSERT_IMPL(a_never_busy, 1'b1, !busy)
    `MRIC_ASSERT_IMPL(a_cfg_ready, 1'b1, cfg_ready)
    `MRIC_ASSERT_IMPL(a_done_known, 1'b1, !$isunknown(done))
    `MRIC_ASSERT_IMPL(a_flat_known, done, !$isunknown(flat_out))
endmodule

bind mixed_radix_index_convert mric_checker u_mric_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .done(done),
    .flat_out(flat_out)
);

// File: sim/mixed_radix_index_convert_check.sv
module mixed_radix_index_convert_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           mode,
    input  logic [mric_pkg::FLAT_W-1:0]    flat_in,
    input  mric_pkg::size_t                index_in_0,
    input  mric_pkg::size_t                index_in_1,
    input  mric_pkg::size_t                index_in_2,
    input  mric_pkg::size_t                index_in_3,
    input  mric_pkg::size_t                index_in_4,
    input  mric_pkg::size_t                index_in_5,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [mric_pkg::CFG_IDX_W-1:0] cfg_index,
    input  mric_pkg::size_t                cfg_data,
    input  logic                           done,
    input  logic [mric_pkg::FLAT_W-1:0]    flat_out,
    input  mric_pkg::size_t                index_out_0,
    input  mric_pkg::size_t                index_out_1,
    input  mric_pkg::size_t                index_out_2,
    input  mric_pkg::size_t                index_out_3,
    input  mric_pkg::size_t                index_out_4,
    input  mric_pkg::size_t                index_out_5,
    output int                             mismatch_count,
    output int                             pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import mric_pkg::*;

    typedef struct packed {
        logic [FLAT_W-1:0] flat;
        size_t [AXIS_FIELDS-1:0] idx;
    } conv_result_t;

    size_t axis_size [AXIS_FIELDS];
    conv_result_t expected_q[$];

    function automatic conv_result_t convert(logic m, logic [FLAT_W-1:0] flat,
                                             size_t [AXIS_FIELDS-1:0] idx);
        conv_result_t r;
        logic [FLAT_W-1:0] pitch;
        logic [FLAT_W-1:0] rest;
        logic [FLAT_W-1:0] s;
        r = '0;
        pitch = 1;
        rest = flat;
        for (int k = AXIS_FIELDS - 1; k >= 0; k--)
        begin
            s = (axis_size[k] == 0) ? 1 : FLAT_W'(axis_size[k]);
            if (m == MODE_COMPOSE)
            begin
                r.flat = r.flat + pitch * FLAT_W'(idx[k]);
                pitch = pitch * s;
            end
            else
            begin
                r.idx[k] = size_t'(rest % s);
                rest = rest / s;
            end
        end
        return r;
    endfunction

    assign pending_count = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        conv_result_t got;
        conv_result_t want;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            for (int k = 0; k < AXIS_FIELDS; k++)
                axis_size[k] = 1;
            expected_q.delete();
            mismatch_count <= 0;
        end
        else
        begin
            if (done)
            begin
                got.flat = flat_out;
                got.idx = {index_out_5, index_out_4, index_out_3,
                           index_out_2, index_out_1, index_out_0};
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result flat=%h idx=%h", $time, got.flat, got.idx);
                    errs++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.flat !== want.flat)
                    begin
                        $display("%0t: flat_out expected %h actual %h",
                                 $time, want.flat, got.flat);
                        errs++;
                    end
                    for (int k = 0; k < AXIS_FIELDS; k++)
                        if (got.idx[k] !== want.idx[k])
                        begin
                            $display("%0t: index_out_%0d expected %h actual %h",
                                     $time, k, want.idx[k], got.idx[k]);
                            errs++;
                        end
                end
            end
            if (errs != 0)
                mismatch_count <= mismatch_count + errs;
            if (start && !busy)
                expected_q.push_back(convert(mode, flat_in,
                    {index_in_5, index_in_4, index_in_3,
                     index_in_2, index_in_1, index_in_0}));
            if (cfg_valid && cfg_ready && cfg_index < AXIS_FIELDS)
                axis_size[cfg_index] = cfg_data;
        end
    end
endmodule

// File: sim/mixed_radix_index_convert_test.sv
module mixed_radix_index_convert_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mric_pkg::*;

    localparam int LATENCY = INDEX_BITS_DEF * NUM_AXES_DEF + 1;
    localparam int STALL_LIMIT = 20000;

    logic clk, rst_n, start, busy, mode, cfg_valid, cfg_ready, done;
    logic [FLAT_W-1:0] flat_in, flat_out;
    logic [CFG_IDX_W-1:0] cfg_index;
    size_t cfg_data;
    size_t index_in_0, index_in_1, index_in_2, index_in_3, index_in_4, index_in_5;
    size_t index_out_0, index_out_1, index_out_2, index_out_3, index_out_4, index_out_5;
    int mismatch_count, pending_count;
    int n_compose, n_decompose, n_cfg;
    int idle_pct;
    size_t grid [AXIS_FIELDS];

    mixed_radix_index_convert dut (.*);
    mixed_radix_index_convert_check checker_i (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send(logic m, logic [FLAT_W-1:0] f, size_t i0, size_t i1, size_t i2,
                        size_t i3, size_t i4, size_t i5);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1;
        mode <= m;
        flat_in <= f;
        index_in_0 <= i0; index_in_1 <= i1; index_in_2 <= i2;
        index_in_3 <= i3; index_in_4 <= i4; index_in_5 <= i5;
        do @(posedge clk); while (busy);
        if (m == MODE_COMPOSE) n_compose++; else n_decompose++;
    endtask

    task automatic drain();
        start <= 0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_grid(int s0, int s1, int s2, int s3, int s4, int s5);
        size_t v [8];
        v = '{size_t'(s0), size_t'(s1), size_t'(s2), size_t'(s3), size_t'(s4),
              size_t'(s5), size_t'($urandom), size_t'($urandom)};
        for (int k = 0; k < 8; k++)
        begin
            cfg_valid <= 1;
            cfg_index <= CFG_IDX_W'(k);
            cfg_data <= v[k];
            do @(posedge clk); while (!cfg_ready);
            n_cfg++;
        end
        cfg_valid <= 0;
        for (int k = 0; k < AXIS_FIELDS; k++)
            grid[k] = v[k];
    endtask

    function automatic size_t pick_index(size_t s);
        if ($urandom_range(9) == 0 || s == 0)
            return size_t'($urandom_range(65534));
        return size_t'($urandom_range(s - 1 > 65534 ? 65534 : s - 1));
    endfunction

    task automatic random_items(int count);
        logic [63:0] span;
        logic [FLAT_W-1:0] f;
        span = 1;
        for (int k = 0; k < AXIS_FIELDS; k++)
            span = span * (grid[k] == 0 ? 1 : grid[k]);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(9) < 8 && span <= 64'hFFFF_FFFF)
                f = $urandom_range(32'(span - 1));
            else
                f = $urandom;
            send(1'($urandom_range(1)), f, pick_index(grid[0]), pick_index(grid[1]),
                 pick_index(grid[2]), pick_index(grid[3]), pick_index(grid[4]),
                 pick_index(grid[5]));
        end
    endtask

    initial
    begin
        int pcts [4];
        pcts = '{0, 64, 64, 35};
        rst_n = 0; start = 0; mode = 0; flat_in = 0; cfg_valid = 0; cfg_index = 0;
        cfg_data = 0;
        index_in_0 = 0; index_in_1 = 0; index_in_2 = 0;
        index_in_3 = 0; index_in_4 = 0; index_in_5 = 0;
        n_compose = 0; n_decompose = 0; n_cfg = 0; idle_pct = 0;
        for (int k = 0; k < AXIS_FIELDS; k++) grid[k] = 1;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset sizes: every axis size 1
        send(MODE_COMPOSE, 0, 0, 0, 0, 0, 0, 0);
        send(MODE_COMPOSE, '1, 65534, 65534, 65534, 65534, 65534, 65534);
        send(MODE_COMPOSE, 0, 16'h5555, 16'h2AAA, 1, 2, 3, 65533);
        send(MODE_DECOMPOSE, '1, 7, 7, 7, 7, 7, 7);
        send(MODE_DECOMPOSE, 0, 0, 0, 0, 0, 0, 0);
        drain();

        write_grid(3, 5, 7, 2, 4, 6);
        send(MODE_COMPOSE, 0, 2, 4, 6, 1, 3, 5);
        send(MODE_DECOMPOSE, 5039, 0, 0, 0, 0, 0, 0);
        send(MODE_DECOMPOSE, 5040, 0, 0, 0, 0, 0, 0);
        send(MODE_COMPOSE, 0, 65534, 0, 0, 0, 0, 65534);
        send(MODE_DECOMPOSE, 32'hAAAA_5555, 0, 0, 0, 0, 0, 0);
        drain();

        // zero sizes behave as one
        write_grid(0, 65535, 0, 0, 65535, 0);
        send(MODE_COMPOSE, 0, 65534, 65534, 65534, 65534, 65534, 65534);
        send(MODE_DECOMPOSE, '1, 0, 0, 0, 0, 0, 0);
        drain();

        // pitch products wrap
        write_grid(65535, 65535, 65535, 65535, 65535, 65535);
        send(MODE_COMPOSE, 0, 65534, 65534, 65534, 65534, 65534, 65534);
        send(MODE_DECOMPOSE, '1, 0, 0, 0, 0, 0, 0);
        send(MODE_DECOMPOSE, 32'h0001_0000, 0, 0, 0, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: write_grid($urandom_range(1, 16), $urandom_range(1, 16),
                              $urandom_range(1, 16), $urandom_range(1, 16),
                              $urandom_range(1, 16), $urandom_range(1, 16));
                1: write_grid($urandom_range(1, 65535), $urandom_range(1, 65535),
                              $urandom_range(1, 65535), $urandom_range(1, 65535),
                              $urandom_range(1, 65535), $urandom_range(1, 65535));
                2: write_grid($urandom_range(0, 3), $urandom_range(1, 300),
                              $urandom_range(0, 1), $urandom_range(1, 300),
                              $urandom_range(0, 65535), $urandom_range(1, 65535));
                default: write_grid(1, 1, 1, 1, 1, 1);
            endcase
            idle_pct = pcts[ph % 4];
            random_items(140);
            drain();
        end
        idle_pct = 0;

        $display("covered %0d compose and %0d decompose requests", n_compose,
                 n_decompose);
        $display("over %0d register writes on small, large and zero-size grids", n_cfg);
        if (mismatch_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            $display("leftover requests: %0d", pending_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
